### rtl/mtoc_pkg.sv
// Package for the address table occupancy counters: sizes, codes, types and helpers.
`default_nettype none

package mtoc_pkg;

  localparam int NUM_PORTS      = 64;
  localparam int NUM_VLANS      = 4094;
  localparam int TABLE_CAPACITY = 16384;

  localparam int CNT_W     = $clog2(TABLE_CAPACITY + 1);
  localparam int OUT_W     = 15;
  localparam int PORT_AW   = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int VLAN_AW   = (NUM_VLANS > 1) ? $clog2(NUM_VLANS) : 1;
  localparam int CLEAR_LEN = (NUM_PORTS > NUM_VLANS) ? NUM_PORTS : NUM_VLANS;
  localparam int CLEAR_W   = (CLEAR_LEN > 1) ? $clog2(CLEAR_LEN) : 1;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;

  localparam logic [1:0] LIFE_CREATING = 2'd0;
  localparam logic [1:0] LIFE_DYNAMIC  = 2'd1;

  localparam logic [2:0] SRC_SELF   = 3'd0;
  localparam logic [2:0] SRC_LEARNT = 3'd1;
  localparam logic [2:0] SRC_SECURE = 3'd2;
  localparam logic [2:0] SRC_CONFIG = 3'd3;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  lifetime_class;
    logic [2:0]  entry_source;
    logic [6:0]  port_number;
    logic [11:0] vlan_id;
  } item_t;

  typedef struct packed {
    cnt_t stat;
    cnt_t dyn;
    cnt_t learnt;
    cnt_t secure;
    cnt_t configured;
  } port_cnt_t;

  typedef struct packed {
    cnt_t stat;
    cnt_t dyn;
  } vlan_cnt_t;

  typedef struct packed {
    cnt_t stat;
    cnt_t dyn;
    cnt_t all;
  } total_cnt_t;

  function automatic logic port_in_range(logic [6:0] port_number);
    return (port_number != 7'd0) && (32'(port_number) <= NUM_PORTS);
  endfunction

  function automatic logic vlan_in_range(logic [11:0] vlan_id);
    return (vlan_id != 12'd0) && (32'(vlan_id) <= NUM_VLANS);
  endfunction

  function automatic logic [PORT_AW-1:0] port_index(logic [6:0] port_number);
    return PORT_AW'(port_number - 7'd1);
  endfunction

  function automatic logic [VLAN_AW-1:0] vlan_index(logic [11:0] vlan_id);
    return VLAN_AW'(vlan_id - 12'd1);
  endfunction

  // Saturating step: stops at zero going down and at capacity going up.
  function automatic cnt_t bump(cnt_t c, logic up, logic en);
    cnt_t r;
    r = c;
    if (en) begin
      if (up) begin
        if (c < CNT_W'(TABLE_CAPACITY)) r = c + cnt_t'(1);
      end else begin
        if (c != '0) r = c - cnt_t'(1);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/mac_table_occupancy_counters.sv
// Top level of the address table occupancy counters.
//
// One input word per add, remove or read event; one result word per input
// word, carrying the counters of the word's port and VLAN after the update.
// Both channels use valid/ready. A word accepted at one edge has its counter
// memories read at that edge; the update state that follows modifies and
// writes them back and loads the result register. No new word is accepted
// until that update completes. The read and update steps are split by the
// registered read data of the per-port and per-VLAN counter memories.
// The next word may be accepted while a result waits in the output register;
// if that result is still not taken when the following word's result is
// ready, the block holds in its modify cycle until the receiver takes it.
// After reset a clearing pass zeroes both memories, one entry per cycle,
// over max(NUM_PORTS, NUM_VLANS) addresses (4094 at the default sizes); no word
// is accepted during that pass. The three totals live in registers and
// clear at once. All counters saturate at zero and at table capacity.
`default_nettype none

module mac_table_occupancy_counters (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  op,
  input  wire logic [1:0]  lifetime_class,
  input  wire logic [2:0]  entry_source,
  input  wire logic [6:0]  port_number,
  input  wire logic [11:0] vlan_id,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [14:0]      port_static,
  output logic [14:0]      port_dynamic,
  output logic [14:0]      port_learnt,
  output logic [14:0]      port_secure,
  output logic [14:0]      port_configured,
  output logic [14:0]      vlan_static,
  output logic [14:0]      vlan_dynamic,
  output logic [14:0]      all_static,
  output logic [14:0]      all_dynamic,
  output logic [14:0]      all_entries
);

  localparam int PORT_W = $bits(mtoc_pkg::port_cnt_t);
  localparam int VLAN_W = $bits(mtoc_pkg::vlan_cnt_t);

  mtoc_pkg::state_t     state;
  mtoc_pkg::state_t     state_next;
  logic [mtoc_pkg::CLEAR_W-1:0] clr_cnt;
  mtoc_pkg::item_t      item;
  mtoc_pkg::total_cnt_t totals;

  logic accept;
  logic done;
  logic clearing;
  logic clear_last;

  mtoc_pkg::port_cnt_t  port_rd;
  mtoc_pkg::vlan_cnt_t  vlan_rd;
  mtoc_pkg::port_cnt_t  port_wr;
  mtoc_pkg::vlan_cnt_t  vlan_wr;
  mtoc_pkg::total_cnt_t tot_next;
  logic port_ok;
  logic vlan_ok;

  logic                        port_we;
  logic [mtoc_pkg::PORT_AW-1:0] port_waddr;
  logic [PORT_W-1:0]            port_wdata;
  logic                        vlan_we;
  logic [mtoc_pkg::VLAN_AW-1:0] vlan_waddr;
  logic [VLAN_W-1:0]            vlan_wdata;

  assign clear_last = (32'(clr_cnt) == mtoc_pkg::CLEAR_LEN - 1);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      mtoc_pkg::ST_CLEAR: begin
        if (clear_last) state_next = mtoc_pkg::ST_IDLE;
      end
      mtoc_pkg::ST_IDLE: begin
        if (in_valid) state_next = mtoc_pkg::ST_UPDATE;
      end
      mtoc_pkg::ST_UPDATE: begin
        if (!out_valid || out_ready) state_next = mtoc_pkg::ST_IDLE;
      end
      default: state_next = mtoc_pkg::ST_CLEAR;
    endcase
  end

  // Control outputs of the state machine.
  always_comb begin
    in_ready = 1'b0;
    clearing = 1'b0;
    done     = 1'b0;
    case (state)
      mtoc_pkg::ST_CLEAR:  clearing = 1'b1;
      mtoc_pkg::ST_IDLE:   in_ready = 1'b1;
      mtoc_pkg::ST_UPDATE: done = !out_valid || out_ready;
      default: begin
      end
    endcase
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mtoc_pkg::ST_CLEAR;
      clr_cnt   <= '0;
      totals    <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (done) begin
        totals    <= tot_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.op             <= op;
      item.lifetime_class <= lifetime_class;
      item.entry_source   <= entry_source;
      item.port_number    <= port_number;
      item.vlan_id        <= vlan_id;
    end
  end

  // Write ports: zeroes during the clearing pass, new counts on completion.
  always_comb begin
    if (clearing) begin
      port_we    = (32'(clr_cnt) < mtoc_pkg::NUM_PORTS);
      port_waddr = mtoc_pkg::PORT_AW'(clr_cnt);
      port_wdata = '0;
      vlan_we    = (32'(clr_cnt) < mtoc_pkg::NUM_VLANS);
      vlan_waddr = mtoc_pkg::VLAN_AW'(clr_cnt);
      vlan_wdata = '0;
    end else begin
      port_we    = done && port_ok;
      port_waddr = mtoc_pkg::port_index(item.port_number);
      port_wdata = port_wr;
      vlan_we    = done && vlan_ok;
      vlan_waddr = mtoc_pkg::vlan_index(item.vlan_id);
      vlan_wdata = vlan_wr;
    end
  end

  mtoc_ram #(
    .WIDTH (PORT_W),
    .DEPTH (mtoc_pkg::NUM_PORTS)
  ) u_port_ram (
    .clk   (clk),
    .we    (port_we),
    .waddr (port_waddr),
    .wdata (port_wdata),
    .re    (accept),
    .raddr (mtoc_pkg::port_index(port_number)),
    .rdata (port_rd)
  );

  mtoc_ram #(
    .WIDTH (VLAN_W),
    .DEPTH (mtoc_pkg::NUM_VLANS)
  ) u_vlan_ram (
    .clk   (clk),
    .we    (vlan_we),
    .waddr (vlan_waddr),
    .wdata (vlan_wdata),
    .re    (accept),
    .raddr (mtoc_pkg::vlan_index(vlan_id)),
    .rdata (vlan_rd)
  );

  mtoc_update u_update (
    .item     (item),
    .port_rd  (port_rd),
    .vlan_rd  (vlan_rd),
    .tot_cur  (totals),
    .port_wr  (port_wr),
    .vlan_wr  (vlan_wr),
    .tot_next (tot_next),
    .port_ok  (port_ok),
    .vlan_ok  (vlan_ok)
  );

  // Result register; fields of an out-of-range port or VLAN read zero.
  always_ff @(posedge clk) begin
    if (done) begin
      port_static     <= port_ok ? mtoc_pkg::OUT_W'(port_wr.stat) : '0;
      port_dynamic    <= port_ok ? mtoc_pkg::OUT_W'(port_wr.dyn) : '0;
      port_learnt     <= port_ok ? mtoc_pkg::OUT_W'(port_wr.learnt) : '0;
      port_secure     <= port_ok ? mtoc_pkg::OUT_W'(port_wr.secure) : '0;
      port_configured <= port_ok ? mtoc_pkg::OUT_W'(port_wr.configured) : '0;
      vlan_static     <= vlan_ok ? mtoc_pkg::OUT_W'(vlan_wr.stat) : '0;
      vlan_dynamic    <= vlan_ok ? mtoc_pkg::OUT_W'(vlan_wr.dyn) : '0;
      all_static      <= mtoc_pkg::OUT_W'(tot_next.stat);
      all_dynamic     <= mtoc_pkg::OUT_W'(tot_next.dyn);
      all_entries     <= mtoc_pkg::OUT_W'(tot_next.all);
    end
  end

endmodule

`default_nettype wire

### rtl/mtoc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module mtoc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/mtoc_update.sv
// Modify stage: new counter values from the read data and the held word.
`default_nettype none

module mtoc_update (
  input  wire mtoc_pkg::item_t      item,
  input  wire mtoc_pkg::port_cnt_t  port_rd,
  input  wire mtoc_pkg::vlan_cnt_t  vlan_rd,
  input  wire mtoc_pkg::total_cnt_t tot_cur,
  output mtoc_pkg::port_cnt_t       port_wr,
  output mtoc_pkg::vlan_cnt_t       vlan_wr,
  output mtoc_pkg::total_cnt_t      tot_next,
  output logic                      port_ok,
  output logic                      vlan_ok
);

  logic change;
  logic up;
  logic formed;
  logic dyn_en;
  logic stat_en;

  always_comb begin
    port_ok = mtoc_pkg::port_in_range(item.port_number);
    vlan_ok = mtoc_pkg::vlan_in_range(item.vlan_id);
    change  = (item.op == mtoc_pkg::OP_ADD) || (item.op == mtoc_pkg::OP_REMOVE);
    up      = (item.op == mtoc_pkg::OP_ADD);
    formed  = change && (item.lifetime_class != mtoc_pkg::LIFE_CREATING) &&
              (item.entry_source != mtoc_pkg::SRC_SELF) && port_ok && vlan_ok;
    dyn_en  = formed && (item.lifetime_class == mtoc_pkg::LIFE_DYNAMIC);
    stat_en = formed && (item.lifetime_class != mtoc_pkg::LIFE_DYNAMIC);

    port_wr.stat       = mtoc_pkg::bump(port_rd.stat, up, stat_en);
    port_wr.dyn        = mtoc_pkg::bump(port_rd.dyn, up, dyn_en);
    port_wr.learnt     = mtoc_pkg::bump(port_rd.learnt, up,
                           formed && (item.entry_source == mtoc_pkg::SRC_LEARNT));
    port_wr.secure     = mtoc_pkg::bump(port_rd.secure, up,
                           formed && (item.entry_source == mtoc_pkg::SRC_SECURE));
    port_wr.configured = mtoc_pkg::bump(port_rd.configured, up,
                           formed && (item.entry_source == mtoc_pkg::SRC_CONFIG));

    vlan_wr.stat = mtoc_pkg::bump(vlan_rd.stat, up, stat_en);
    vlan_wr.dyn  = mtoc_pkg::bump(vlan_rd.dyn, up, dyn_en);

    tot_next.stat = mtoc_pkg::bump(tot_cur.stat, up, stat_en);
    tot_next.dyn  = mtoc_pkg::bump(tot_cur.dyn, up, dyn_en);
    tot_next.all  = mtoc_pkg::bump(tot_cur.all, up, change);
  end

endmodule

`default_nettype wire

### tb/mac_table_occupancy_counters_tb.sv
// Self-checking testbench for the address table occupancy counters.
`timescale 1ns / 100ps

module mac_table_occupancy_counters_tb;

  localparam logic [1:0] OP_READ     = 2'd2;
  localparam logic [1:0] OP_SPARE    = 2'd3;
  localparam logic [1:0] LIFE_STATIC = 2'd2;
  localparam logic [1:0] LIFE_SPARE  = 2'd3;
  localparam logic [2:0] SRC_OTHER   = 3'd4;
  localparam logic [2:0] SRC_SPARE   = 3'd7;

  localparam logic [6:0]  LAST_PORT = 7'(mtoc_pkg::NUM_PORTS);
  localparam logic [11:0] LAST_VLAN = 12'(mtoc_pkg::NUM_VLANS);

  localparam int RANDOM_EVENTS = 1600;
  localparam int HOLD_AT       = 400;
  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_FROM    = 800;
  localparam int QUIET_TO      = 900;
  localparam int STALL_LIMIT   = 20000;
  localparam int PRINT_LIMIT   = 50;
  localparam int DIRECTED_LEN  = 19;

  typedef struct packed {
    logic [14:0] port_static;
    logic [14:0] port_dynamic;
    logic [14:0] port_learnt;
    logic [14:0] port_secure;
    logic [14:0] port_configured;
    logic [14:0] vlan_static;
    logic [14:0] vlan_dynamic;
    logic [14:0] all_static;
    logic [14:0] all_dynamic;
    logic [14:0] all_entries;
  } counts_t;

  typedef struct packed {
    mtoc_pkg::item_t ev;
    logic            typed;
    counts_t         want;
  } step_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  op = OP_READ;
  logic [1:0]  lifetime_class = mtoc_pkg::LIFE_CREATING;
  logic [2:0]  entry_source = mtoc_pkg::SRC_SELF;
  logic [6:0]  port_number = 7'd0;
  logic [11:0] vlan_id = 12'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [14:0] port_static, port_dynamic, port_learnt, port_secure, port_configured;
  logic [14:0] vlan_static, vlan_dynamic, all_static, all_dynamic, all_entries;

  // Counter shadow, kept in step with every word the block accepts.
  int unsigned static_on_port [mtoc_pkg::NUM_PORTS];
  int unsigned dynamic_on_port [mtoc_pkg::NUM_PORTS];
  int unsigned learnt_on_port [mtoc_pkg::NUM_PORTS];
  int unsigned secure_on_port [mtoc_pkg::NUM_PORTS];
  int unsigned configured_on_port [mtoc_pkg::NUM_PORTS];
  int unsigned static_in_vlan [mtoc_pkg::NUM_VLANS];
  int unsigned dynamic_in_vlan [mtoc_pkg::NUM_VLANS];
  int unsigned static_all;
  int unsigned dynamic_all;
  int unsigned entries_all;

  counts_t         expected_counts [$];
  mtoc_pkg::item_t added_log [$];
  int      mismatches;
  int      results_checked;
  int      events_sent;
  int      idle_cycles;
  bit      hold_pending;
  bit      steady;

  string field_name [10] = '{"all_entries", "all_dynamic", "all_static", "vlan_dynamic",
                             "vlan_static", "port_configured", "port_secure",
                             "port_learnt", "port_dynamic", "port_static"};

  // Typed expectations cover the counters straight after reset, a remove from an empty table and the first few adds.
  step_t directed_steps [DIRECTED_LEN] = '{
    '{'{OP_READ, mtoc_pkg::LIFE_CREATING, mtoc_pkg::SRC_SELF, 7'd0, 12'd0}, 1'b1, '0},
    '{'{mtoc_pkg::OP_REMOVE, mtoc_pkg::LIFE_DYNAMIC, mtoc_pkg::SRC_LEARNT, 7'd1, 12'd1},
      1'b1, '0},
    '{'{mtoc_pkg::OP_ADD, mtoc_pkg::LIFE_DYNAMIC, mtoc_pkg::SRC_LEARNT, 7'd1, 12'd1}, 1'b1,
      '{15'd0, 15'd1, 15'd1, 15'd0, 15'd0, 15'd0, 15'd1, 15'd0, 15'd1, 15'd1}},
    '{'{mtoc_pkg::OP_ADD, LIFE_STATIC, mtoc_pkg::SRC_SECURE, LAST_PORT, LAST_VLAN}, 1'b1,
      '{15'd1, 15'd0, 15'd0, 15'd1, 15'd0, 15'd1, 15'd0, 15'd1, 15'd1, 15'd2}},
    '{'{mtoc_pkg::OP_ADD, LIFE_SPARE, mtoc_pkg::SRC_CONFIG, LAST_PORT, LAST_VLAN}, 1'b1,
      '{15'd2, 15'd0, 15'd0, 15'd1, 15'd1, 15'd2, 15'd0, 15'd2, 15'd1, 15'd3}},
    '{'{mtoc_pkg::OP_ADD, LIFE_STATIC, SRC_OTHER, LAST_PORT, LAST_VLAN}, 1'b0, '0},
    '{'{mtoc_pkg::OP_ADD, LIFE_STATIC, SRC_SPARE, LAST_PORT, LAST_VLAN}, 1'b0, '0},
    '{'{mtoc_pkg::OP_ADD, mtoc_pkg::LIFE_DYNAMIC, mtoc_pkg::SRC_SELF, 7'd2, 12'd2},
      1'b0, '0},
    '{'{mtoc_pkg::OP_ADD, mtoc_pkg::LIFE_CREATING, mtoc_pkg::SRC_LEARNT, 7'd2, 12'd2},
      1'b0, '0},
    '{'{mtoc_pkg::OP_ADD, mtoc_pkg::LIFE_DYNAMIC, mtoc_pkg::SRC_LEARNT, 7'd0, 12'd5},
      1'b0, '0},
    '{'{mtoc_pkg::OP_ADD, mtoc_pkg::LIFE_DYNAMIC, mtoc_pkg::SRC_LEARNT, LAST_PORT + 7'd1,
        12'd5}, 1'b0, '0},
    '{'{mtoc_pkg::OP_ADD, LIFE_SPARE, SRC_SPARE, 7'h7f, 12'hfff}, 1'b0, '0},
    '{'{mtoc_pkg::OP_ADD, LIFE_STATIC, mtoc_pkg::SRC_SECURE, 7'd3, 12'd0}, 1'b0, '0},
    '{'{OP_SPARE, LIFE_STATIC, mtoc_pkg::SRC_CONFIG, LAST_PORT, LAST_VLAN}, 1'b0, '0},
    '{'{mtoc_pkg::OP_REMOVE, LIFE_STATIC, mtoc_pkg::SRC_CONFIG, LAST_PORT, LAST_VLAN},
      1'b0, '0},
    '{'{mtoc_pkg::OP_REMOVE, mtoc_pkg::LIFE_DYNAMIC, mtoc_pkg::SRC_LEARNT, 7'd1, 12'd1},
      1'b0, '0},
    '{'{OP_READ, mtoc_pkg::LIFE_DYNAMIC, mtoc_pkg::SRC_LEARNT, 7'd1, 12'd1}, 1'b0, '0},
    '{'{mtoc_pkg::OP_REMOVE, mtoc_pkg::LIFE_CREATING, mtoc_pkg::SRC_LEARNT, 7'd2, 12'd2},
      1'b0, '0},
    '{'{mtoc_pkg::OP_REMOVE, LIFE_SPARE, SRC_SPARE, 7'h7f, 12'hfff}, 1'b0, '0}
  };

  mac_table_occupancy_counters i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .op              (op),
    .lifetime_class  (lifetime_class),
    .entry_source    (entry_source),
    .port_number     (port_number),
    .vlan_id         (vlan_id),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .port_static     (port_static),
    .port_dynamic    (port_dynamic),
    .port_learnt     (port_learnt),
    .port_secure     (port_secure),
    .port_configured (port_configured),
    .vlan_static     (vlan_static),
    .vlan_dynamic    (vlan_dynamic),
    .all_static      (all_static),
    .all_dynamic     (all_dynamic),
    .all_entries     (all_entries)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned saturate_step(int unsigned c, bit up);
    if (up) return (c < mtoc_pkg::TABLE_CAPACITY) ? c + 1 : c;
    return (c > 0) ? c - 1 : c;
  endfunction

  // Applies one event to the shadow counters and returns the word the block should report.
  function automatic counts_t count_event(mtoc_pkg::item_t ev);
    bit      port_ok;
    bit      vlan_ok;
    bit      up;
    int      pi;
    int      vi;
    counts_t r;
    port_ok = ev.port_number != 7'd0 && int'(ev.port_number) <= mtoc_pkg::NUM_PORTS;
    vlan_ok = ev.vlan_id != 12'd0 && int'(ev.vlan_id) <= mtoc_pkg::NUM_VLANS;
    pi = port_ok ? int'(ev.port_number) - 1 : 0;
    vi = vlan_ok ? int'(ev.vlan_id) - 1 : 0;
    if (ev.op == mtoc_pkg::OP_ADD || ev.op == mtoc_pkg::OP_REMOVE) begin
      up = ev.op == mtoc_pkg::OP_ADD;
      if (ev.lifetime_class != mtoc_pkg::LIFE_CREATING &&
          ev.entry_source != mtoc_pkg::SRC_SELF && port_ok && vlan_ok) begin
        if (ev.lifetime_class == mtoc_pkg::LIFE_DYNAMIC) begin
          dynamic_on_port[pi] = saturate_step(dynamic_on_port[pi], up);
          dynamic_in_vlan[vi] = saturate_step(dynamic_in_vlan[vi], up);
          dynamic_all = saturate_step(dynamic_all, up);
        end else begin
          static_on_port[pi] = saturate_step(static_on_port[pi], up);
          static_in_vlan[vi] = saturate_step(static_in_vlan[vi], up);
          static_all = saturate_step(static_all, up);
        end
        case (ev.entry_source)
          mtoc_pkg::SRC_LEARNT: learnt_on_port[pi] = saturate_step(learnt_on_port[pi], up);
          mtoc_pkg::SRC_SECURE: secure_on_port[pi] = saturate_step(secure_on_port[pi], up);
          mtoc_pkg::SRC_CONFIG:
            configured_on_port[pi] = saturate_step(configured_on_port[pi], up);
          default: ;
        endcase
      end
      entries_all = saturate_step(entries_all, up);
    end
    r.port_static     = port_ok ? 15'(static_on_port[pi]) : '0;
    r.port_dynamic    = port_ok ? 15'(dynamic_on_port[pi]) : '0;
    r.port_learnt     = port_ok ? 15'(learnt_on_port[pi]) : '0;
    r.port_secure     = port_ok ? 15'(secure_on_port[pi]) : '0;
    r.port_configured = port_ok ? 15'(configured_on_port[pi]) : '0;
    r.vlan_static     = vlan_ok ? 15'(static_in_vlan[vi]) : '0;
    r.vlan_dynamic    = vlan_ok ? 15'(dynamic_in_vlan[vi]) : '0;
    r.all_static      = 15'(static_all);
    r.all_dynamic     = 15'(dynamic_all);
    r.all_entries     = 15'(entries_all);
    return r;
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random events lean towards a few ports and VLANs, and removes mostly undo earlier adds.
  function automatic mtoc_pkg::item_t random_event();
    mtoc_pkg::item_t ev;
    int    r;
    int    k;
    r = $urandom_range(0, 99);
    ev.op = (r < 45) ? mtoc_pkg::OP_ADD : (r < 78) ? mtoc_pkg::OP_REMOVE :
            (r < 93) ? OP_READ : OP_SPARE;
    r = $urandom_range(0, 99);
    ev.lifetime_class = (r < 45) ? mtoc_pkg::LIFE_DYNAMIC : (r < 85) ? LIFE_STATIC :
                        (r < 93) ? mtoc_pkg::LIFE_CREATING : LIFE_SPARE;
    r = $urandom_range(0, 99);
    if (r < 30) ev.entry_source = mtoc_pkg::SRC_LEARNT;
    else if (r < 55) ev.entry_source = mtoc_pkg::SRC_SECURE;
    else if (r < 75) ev.entry_source = mtoc_pkg::SRC_CONFIG;
    else if (r < 88) ev.entry_source = SRC_OTHER;
    else if (r < 94) ev.entry_source = mtoc_pkg::SRC_SELF;
    else ev.entry_source = 3'($urandom_range(int'(SRC_OTHER) + 1, int'(SRC_SPARE)));
    r = $urandom_range(0, 99);
    if (r < 65) ev.port_number = 7'($urandom_range(1, 6));
    else if (r < 88) ev.port_number = 7'($urandom_range(1, mtoc_pkg::NUM_PORTS));
    else ev.port_number = 7'($urandom_range(0, 127));
    r = $urandom_range(0, 99);
    if (r < 60) ev.vlan_id = 12'($urandom_range(1, 12));
    else if (r < 85) ev.vlan_id = 12'($urandom_range(1, mtoc_pkg::NUM_VLANS));
    else ev.vlan_id = 12'($urandom_range(0, 4095));
    if (ev.op == mtoc_pkg::OP_REMOVE && added_log.size() > 0 &&
        $urandom_range(0, 99) < 75) begin
      k = $urandom_range(0, added_log.size() - 1);
      ev = added_log[k];
      ev.op = mtoc_pkg::OP_REMOVE;
      added_log.delete(k);
    end else if (ev.op == mtoc_pkg::OP_ADD) begin
      added_log.push_back(ev);
      if (added_log.size() > 200) added_log.delete(0);
    end
    return ev;
  endfunction

  task automatic report(string msg);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) $display("%0t: %s", $realtime, msg);
  endtask

  // Offers one word after a gap, waits for it to be taken and records what should come back.
  task automatic offer(mtoc_pkg::item_t ev, logic typed, counts_t want, int gap);
    counts_t predicted;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    op             <= ev.op;
    lifetime_class <= ev.lifetime_class;
    entry_source   <= ev.entry_source;
    port_number    <= ev.port_number;
    vlan_id        <= ev.vlan_id;
    do @(posedge clk); while (!in_ready);
    predicted = count_event(ev);
    expected_counts.push_back(typed ? want : predicted);
    events_sent++;
  endtask

  // Receiver: random stalls, a long hold-off on request, none while steady is set.
  initial begin
    int len;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_ready <= 1'b1;
      end else if (steady || rst) begin
        out_ready <= !rst;
      end else begin
        len = pick_gap();
        if (len == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          repeat (len - 1) @(negedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    counts_t got;
    counts_t want;
    logic [9:0][14:0] got_f;
    logic [9:0][14:0] want_f;
    if (!rst && out_valid && out_ready) begin
      got = '{port_static, port_dynamic, port_learnt, port_secure, port_configured,
              vlan_static, vlan_dynamic, all_static, all_dynamic, all_entries};
      if (expected_counts.size() == 0) begin
        report($sformatf("result word %0d arrived with nothing outstanding", results_checked));
      end else begin
        want = expected_counts.pop_front();
        got_f = got;
        want_f = want;
        for (int f = 9; f >= 0; f--) begin
          if (got_f[f] !== want_f[f])
            report($sformatf("result word %0d: %s is %0d, expected %0d", results_checked,
                             field_name[f], got_f[f], want_f[f]));
        end
      end
      results_checked++;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: %0d cycles without a word moving", idle_cycles);
      $display("[mac_table_occupancy_counters] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    mtoc_pkg::item_t ev;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_steps[i])
      offer(directed_steps[i].ev, directed_steps[i].typed, directed_steps[i].want, pick_gap());

    for (int i = 0; i < RANDOM_EVENTS; i++) begin
      if (i == HOLD_AT) hold_pending = 1'b1;
      steady = i >= QUIET_FROM && i < QUIET_TO;
      ev = random_event();
      offer(ev, 1'b0, '0, steady ? 0 : pick_gap());
    end
    steady = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;

    wait (expected_counts.size() == 0);
    repeat (20) @(posedge clk);

    $display("Ran %0d events: directed cases and %0d random events with stalls and a long",
             events_sent, RANDOM_EVENTS);
    $display("hold-off; %0d result words checked, %0d mismatches.",
             results_checked, mismatches);
    if (mismatches == 0 && expected_counts.size() == 0) begin
      $display("[mac_table_occupancy_counters] OK");
    end else begin
      $display("[mac_table_occupancy_counters] ERROR");
    end
    $finish;
  end

endmodule
